// ----- rtl/pwm_period_duty_calculator_top_assert.svh -----
// ---------------------------------------------------------------------------
// pwm period duty calculator assertion macros
// clocked, reset-gated property checks shared by the rtl
// ---------------------------------------------------------------------------
`ifndef PWM_PERIOD_DUTY_CALCULATOR_TOP_ASSERT_SVH
`define PWM_PERIOD_DUTY_CALCULATOR_TOP_ASSERT_SVH

// property checked at every rising edge outside reset
`define PDC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication checked at every rising edge outside reset
`define PDC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pwmpdc_pkg.sv -----
// ---------------------------------------------------------------------------
// pwmpdc_pkg
// types and constants of the pwm period / prescaler / duty calculator
// ---------------------------------------------------------------------------
package pwmpdc_pkg;

  localparam int unsigned ClockHz    = 32000000;
  localparam int unsigned FreqMin    = 500;
  localparam int unsigned FreqMax    = 50000;
  localparam int unsigned CountLimit = 256;

  localparam int unsigned DutyW     = 10;
  localparam int unsigned FreqW     = 16;
  localparam int unsigned DividendW = 23;
  localparam int unsigned QuotW     = 14;
  localparam int unsigned Dividend  = ClockHz / 4;

  typedef struct packed {
    logic [DutyW-1:0] duty_level;
    logic [FreqW-1:0] pwm_freq_hz;
  } req_t;

  typedef struct packed {
    logic [7:0] period_count;
    logic [1:0] prescale_code;
    logic [7:0] duty_high;
    logic [1:0] duty_low;
  } rsp_t;

endpackage

// ----- rtl/pwmpdc_div.sv -----
// ---------------------------------------------------------------------------
// pwmpdc_div
// bit-serial restoring divider: constant dividend over a 16-bit divisor
// ---------------------------------------------------------------------------
module pwmpdc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [pwmpdc_pkg::FreqW-1:0]    divisor_i,
  output logic                            done_o,
  output logic [pwmpdc_pkg::QuotW-1:0]    quot_o
);

  logic                                busy_q;
  logic                                done_q;
  logic [4:0]                          cnt_q;
  logic [pwmpdc_pkg::FreqW-1:0]        div_q;
  logic [pwmpdc_pkg::FreqW-1:0]        rem_q, rem_d;
  logic [pwmpdc_pkg::DividendW-1:0]    quo_q, quo_d;
  logic [pwmpdc_pkg::FreqW:0]          rem_shift;
  logic [pwmpdc_pkg::FreqW+1:0]        diff;
  logic                                ge;

  always_comb begin
    rem_shift = {rem_q, quo_q[pwmpdc_pkg::DividendW-1]};
    diff      = {1'b0, rem_shift} - {2'b00, div_q};
    ge        = !diff[pwmpdc_pkg::FreqW+1];
    rem_d     = ge ? diff[pwmpdc_pkg::FreqW-1:0] : rem_shift[pwmpdc_pkg::FreqW-1:0];
    quo_d     = {quo_q[pwmpdc_pkg::DividendW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(pwmpdc_pkg::DividendW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= pwmpdc_pkg::DividendW'(pwmpdc_pkg::Dividend);
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q[pwmpdc_pkg::QuotW-1:0];

endmodule

// ----- rtl/pwm_period_duty_calculator_top.sv -----
// ---------------------------------------------------------------------------
// pwm_period_duty_calculator_top
// turns a duty level and a pwm frequency into timer period, prescaler and
// 10-bit duty compare settings
// ---------------------------------------------------------------------------
// channel  direction  handshake               payload
// in       input      in_valid_i / in_ready_o  in_req_i   (pwmpdc_pkg::req_t)
// out      output     out_valid_o / out_ready_i out_rsp_o (pwmpdc_pkg::rsp_t)
//
// one request at a time, from accept to result: the bit-serial divider,
// the prescaler steps, the shift-add duty multiply, then the load of the
// output register.
// a new request is taken while a result waits in the output register; the
// next result holds in the last stage until the output register drains.
// reset is asynchronous, active low, and empties the pipeline and output.
// ---------------------------------------------------------------------------
`include "pwm_period_duty_calculator_top_assert.svh"

module pwm_period_duty_calculator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pwmpdc_pkg::req_t   in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pwmpdc_pkg::rsp_t   out_rsp_o
);

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StScale,
    StMul,
    StDone
  } state_e;

  state_e                            state_q;
  logic                              out_valid_q;
  pwmpdc_pkg::rsp_t                  out_q;
  logic [pwmpdc_pkg::DutyW-1:0]      duty_q;
  logic [pwmpdc_pkg::QuotW-1:0]      count_q;
  logic [1:0]                        code_q;
  logic [17:0]                       acc_q;
  logic [3:0]                        mul_cnt_q;

  logic                              accept;
  logic [pwmpdc_pkg::FreqW-1:0]      freq_clamped;
  logic                              div_done;
  logic [pwmpdc_pkg::QuotW-1:0]      div_quot;
  logic [17:0]                       acc_d;
  logic [8:0]                        count_m1;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    if (in_req_i.pwm_freq_hz < pwmpdc_pkg::FreqW'(pwmpdc_pkg::FreqMin)) begin
      freq_clamped = pwmpdc_pkg::FreqW'(pwmpdc_pkg::FreqMin);
    end else if (in_req_i.pwm_freq_hz > pwmpdc_pkg::FreqW'(pwmpdc_pkg::FreqMax)) begin
      freq_clamped = pwmpdc_pkg::FreqW'(pwmpdc_pkg::FreqMax);
    end else begin
      freq_clamped = in_req_i.pwm_freq_hz;
    end
  end

  pwmpdc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .divisor_i (freq_clamped),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  always_comb begin
    acc_d    = {acc_q[16:0], 1'b0} +
               (duty_q[pwmpdc_pkg::DutyW-1] ? {9'd0, count_q[8:0]} : 18'd0);
    count_m1 = count_q[8:0] - 9'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      duty_q      <= '0;
      count_q     <= '0;
      code_q      <= '0;
      acc_q       <= '0;
      mul_cnt_q   <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != StDone) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            duty_q  <= in_req_i.duty_level;
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (div_done) begin
            count_q <= div_quot;
            code_q  <= 2'd0;
            state_q <= StScale;
          end
        end
        StScale: begin
          if (count_q > pwmpdc_pkg::QuotW'(pwmpdc_pkg::CountLimit) && code_q != 2'd3) begin
            count_q <= count_q >> 2;
            code_q  <= code_q + 2'd1;
          end else begin
            acc_q     <= '0;
            mul_cnt_q <= '0;
            state_q   <= StMul;
          end
        end
        StMul: begin
          acc_q     <= acc_d;
          duty_q    <= duty_q << 1;
          mul_cnt_q <= mul_cnt_q + 4'd1;
          if (mul_cnt_q == 4'(pwmpdc_pkg::DutyW - 1)) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.period_count  <= count_m1[7:0];
            out_q.prescale_code <= code_q;
            out_q.duty_high     <= acc_q[17:10];
            out_q.duty_low      <= acc_q[9:8];
            out_valid_q         <= 1'b1;
            state_q             <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `PDC_ASSERT_IMP(a_done_in_div, div_done, state_q == StDiv, "divider done outside divide")
  `PDC_ASSERT(a_accept_starts, accept |=> state_q == StDiv, "accepted request did not start")
  `PDC_ASSERT_IMP(a_scaled_count, state_q == StMul,
                  count_q <= pwmpdc_pkg::QuotW'(pwmpdc_pkg::CountLimit),
                  "count above limit after scaling")
  `PDC_ASSERT_IMP(a_prescaled_period, out_valid_o && out_rsp_o.prescale_code != 2'd0,
                  out_rsp_o.period_count >= 8'd63, "prescaled period too short")

endmodule

// ----- verif/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the pwm period / prescaler / duty calculator:
// directed table then random requests over the whole 16-bit frequency and
// 10-bit duty range, random idling on both channels, every result checked
// in order against the typed table values or a behavioral model of the timer settings
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DutyScale = 1024;
  localparam int unsigned NumRand   = 2000;
  localparam int unsigned StallMax  = 2000;
  localparam int unsigned DirN      = 23;

  typedef struct packed {
    pwmpdc_pkg::req_t req;
    bit               typed;
    pwmpdc_pkg::rsp_t want;
  } row_t;

  // period, prescale, duty high, duty low typed where obvious
  localparam row_t DirTab [DirN] = '{
    '{'{10'd0,    16'd500},   1'b1, '{8'd249, 2'd3, 8'd0,   2'd0}},
    '{'{10'd1023, 16'd500},   1'b1, '{8'd249, 2'd3, 8'd249, 2'd3}},
    '{'{10'd0,    16'd50000}, 1'b1, '{8'd159, 2'd0, 8'd0,   2'd0}},
    '{'{10'd1023, 16'd50000}, 1'b1, '{8'd159, 2'd0, 8'd159, 2'd3}},
    '{'{10'd1023, 16'd31250}, 1'b1, '{8'd255, 2'd0, 8'd255, 2'd3}},
    '{'{10'd512,  16'd31250}, 1'b1, '{8'd255, 2'd0, 8'd128, 2'd0}},
    '{'{10'd1023, 16'd0},     1'b1, '{8'd249, 2'd3, 8'd249, 2'd3}},
    '{'{10'd1023, 16'd65535}, 1'b1, '{8'd159, 2'd0, 8'd159, 2'd3}},
    '{'{10'd0,    16'd499},   1'b1, '{8'd249, 2'd3, 8'd0,   2'd0}},
    '{'{10'd1,    16'd50001}, 1'b1, '{8'd159, 2'd0, 8'd0,   2'd0}},
    '{'{10'd1,    16'd31251}, 1'b0, '0},
    '{'{10'd1023, 16'd7812},  1'b0, '0},
    '{'{10'd1023, 16'd7813},  1'b0, '0},
    '{'{10'd1023, 16'd1953},  1'b0, '0},
    '{'{10'd1023, 16'd1954},  1'b0, '0},
    '{'{10'd341,  16'd1000},  1'b0, '0},
    '{'{10'd682,  16'd20000}, 1'b0, '0},
    '{'{10'd1,    16'd500},   1'b0, '0},
    '{'{10'd1000, 16'd2000},  1'b0, '0},
    '{'{10'd256,  16'd12345}, 1'b0, '0},
    '{'{10'd768,  16'd40000}, 1'b0, '0},
    '{'{10'd1023, 16'd10000}, 1'b0, '0},
    '{'{10'd3,    16'd501},   1'b0, '0}
  };

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  pwmpdc_pkg::req_t in_req;
  logic             out_valid;
  logic             out_ready;
  pwmpdc_pkg::rsp_t out_rsp;

  bit               row_typed;
  pwmpdc_pkg::rsp_t row_want;
  bit               snd_idle;
  pwmpdc_pkg::rsp_t timer_q[$];
  pwmpdc_pkg::rsp_t want;
  int unsigned      mismatch_cnt;
  int unsigned      quiet_cycles;

  pwm_period_duty_calculator_top DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic pwmpdc_pkg::rsp_t calc_timer(pwmpdc_pkg::req_t r);
    int unsigned      f;
    int unsigned      cnt;
    int unsigned      code;
    int unsigned      per;
    int unsigned      cmp;
    pwmpdc_pkg::rsp_t res;
    f = r.pwm_freq_hz;
    if (f < pwmpdc_pkg::FreqMin) f = pwmpdc_pkg::FreqMin;
    if (f > pwmpdc_pkg::FreqMax) f = pwmpdc_pkg::FreqMax;
    cnt  = (pwmpdc_pkg::ClockHz / f) / 4;
    code = 0;
    while (cnt > pwmpdc_pkg::CountLimit && code < 3) begin
      cnt  = cnt / 4;
      code = code + 1;
    end
    per = (cnt - 1) & 32'hff;
    cmp = (((per + 1) * r.duty_level * 4) / DutyScale) & 32'h3ff;
    res.period_count  = per[7:0];
    res.prescale_code = code[1:0];
    res.duty_high     = cmp[9:2];
    res.duty_low      = cmp[1:0];
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  task automatic send_req(input pwmpdc_pkg::req_t r, input bit typed,
                          input pwmpdc_pkg::rsp_t w);
    int gap;
    if ($urandom_range(0, 49) == 0) snd_idle = !snd_idle;
    gap = snd_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_req    <= r;
    row_typed <= typed;
    row_want  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (timer_q.size() != 0);
  endtask

  // request side
  initial begin
    pwmpdc_pkg::req_t r;
    int               k;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    row_typed = 1'b0;
    row_want  = '0;
    snd_idle  = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (DirTab[i]) send_req(DirTab[i].req, DirTab[i].typed, DirTab[i].want);
    drain();
    for (int n = 0; n < NumRand; n++) begin
      case ($urandom_range(0, 9))
        0: r.pwm_freq_hz = 16'($urandom_range(0, 65535));
        1: r.pwm_freq_hz = 16'($urandom_range(0, pwmpdc_pkg::FreqMin - 1));
        2: r.pwm_freq_hz = 16'($urandom_range(pwmpdc_pkg::FreqMax + 1, 65535));
        3: begin
          k = $urandom_range(0, 3);
          r.pwm_freq_hz = 16'((k == 0 ? 31250 : k == 1 ? 7812 : k == 2 ? 1953 :
                               pwmpdc_pkg::FreqMin) + $urandom_range(0, 6) - 3);
        end
        default: r.pwm_freq_hz = 16'($urandom_range(pwmpdc_pkg::FreqMin,
                                                    pwmpdc_pkg::FreqMax));
      endcase
      case ($urandom_range(0, 7))
        0: r.duty_level = '0;
        1: r.duty_level = '1;
        default: r.duty_level = 10'($urandom_range(0, 1023));
      endcase
      send_req(r, 1'b0, '0);
      if (n == NumRand / 2 || $urandom_range(0, 299) == 0) drain();
    end
    drain();
    repeat (50) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // result side
  initial begin
    int stall;
    bit idle_on;
    out_ready = 1'b0;
    idle_on   = 1'b1;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 49) == 0) idle_on = !idle_on;
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial mismatch_cnt = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) timer_q.push_back(row_typed ? row_want : calc_timer(in_req));
      if (out_valid && out_ready) begin
        if (timer_q.size() == 0) begin
          $display("%0t: unexpected result expected none got %p", $time, out_rsp);
          mismatch_cnt++;
        end else begin
          want = timer_q.pop_front();
          check_field("period_count", want.period_count, out_rsp.period_count);
          check_field("prescale_code", want.prescale_code, out_rsp.prescale_code);
          check_field("duty_high", want.duty_high, out_rsp.duty_high);
          check_field("duty_low", want.duty_low, out_rsp.duty_low);
        end
      end
    end
  end

  initial quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallMax) begin
      $display("%0t: timeout, %0d results outstanding", $time, timer_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
